/* src/sphpa_pkg.sv */
// shared types and constants for the sph particle accumulator
package sphpa_pkg;

	localparam int WORD_W = 32;
	localparam int CFG_W  = 31;
	localparam int PROD_W = 2 * WORD_W;

	localparam logic [CFG_W-1:0] RADIUS_RST     = 31'd65536;
	localparam logic [CFG_W-1:0] DENS_SCALE_RST = 31'd156469;
	localparam logic [CFG_W-1:0] SLOPE_SCALE_RST = 31'd312939;
	localparam logic [CFG_W-1:0] VISC_SCALE_RST = 31'd102688;
	localparam logic [CFG_W-1:0] PRESS_GAIN_RST = 31'd65536;
	localparam logic [CFG_W-1:0] VISC_GAIN_RST  = 31'd65536;

	typedef enum logic [2:0] {
		REG_RADIUS      = 3'd0,
		REG_DENS_SCALE  = 3'd1,
		REG_SLOPE_SCALE = 3'd2,
		REG_VISC_SCALE  = 3'd3,
		REG_PRESS_GAIN  = 3'd4,
		REG_VISC_GAIN   = 3'd5
	} cfg_reg_t;

	typedef enum logic {
		OP_LOAD      = 1'b0,
		OP_NEIGHBOUR = 1'b1
	} opcode_t;

	typedef enum logic [5:0] {
		ST_IDLE, ST_OFF, ST_SQ, ST_SQ_ACC, ST_ROOT, ST_ROOT_W,
		ST_DK1, ST_DK2, ST_DK3,
		ST_P1, ST_P2, ST_P3, ST_P4,
		ST_PD, ST_PD_W, ST_PM1, ST_PM2, ST_PM3, ST_PM_W,
		ST_W1, ST_W2, ST_W3, ST_W4, ST_W5, ST_W6,
		ST_V1, ST_V2, ST_FIN,
		ST_FD1, ST_FD2, ST_FD3, ST_FV1, ST_FV2, ST_EMIT
	} state_t;

endpackage

/* src/sph_particle_accumulator_core.sv */
// top level: sequencer and datapath of the sph particle accumulator
//
// usage: items arrive on the item channel (item_valid / item_stall). an item
// with opcode load stores the centre particle and clears the sums; it gives no
// result. neighbour items are folded into the sums one at a time; a neighbour
// with last set gives one result transaction on the result channel
// (result_valid / result_stall) with the density sum, pressure force and
// viscous force.
// item_stall is high while a neighbour is being worked on. a neighbour out of
// support on one axis skips the rest of the work; one that fails the radius
// after the square root skips the kernel; a coincident neighbour or one with
// zero centre density adds only the density and viscous terms; any other
// neighbour inside the radius also runs six divisions on the divider and the
// pressure steps. a last neighbour adds the final scaling and the emit step.
// all products go through one shared 32x32 multiplier.
// the result sits in an output register; a new item is taken while it waits,
// and a following result holds in the emit step until the register is free.
// reset (arst_n low) restores the register defaults and clears centre state
// and sums. configuration writes (cfg_write) take effect at once.
module sph_particle_accumulator_core import sphpa_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     item_valid,
	output logic                     item_stall,
	input  logic                     opcode,
	input  logic signed [WORD_W-1:0] pos_x,
	input  logic signed [WORD_W-1:0] pos_y,
	input  logic signed [WORD_W-1:0] pos_z,
	input  logic signed [WORD_W-1:0] vel_x,
	input  logic signed [WORD_W-1:0] vel_y,
	input  logic signed [WORD_W-1:0] vel_z,
	input  logic [CFG_W-1:0]         density,
	input  logic                     last,
	output logic                     result_valid,
	input  logic                     result_stall,
	output logic [CFG_W-1:0]         density_sum,
	output logic signed [WORD_W-1:0] pressure_x,
	output logic signed [WORD_W-1:0] pressure_y,
	output logic signed [WORD_W-1:0] pressure_z,
	output logic signed [WORD_W-1:0] viscous_x,
	output logic signed [WORD_W-1:0] viscous_y,
	output logic signed [WORD_W-1:0] viscous_z,
	input  logic                     cfg_write,
	input  logic [2:0]               cfg_index,
	input  logic [CFG_W-1:0]         cfg_data
);

	localparam int MAG_W = WORD_W + FRAC_BITS;
	localparam logic signed [WORD_W-1:0] ONE_Q = WORD_W'(64'd1 << FRAC_BITS);
	localparam logic signed [PROD_W-1:0] S32_MAX = 64'sd2147483647;
	localparam logic signed [PROD_W-1:0] S32_MIN = -64'sd2147483648;

	function automatic logic signed [WORD_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
		if (v > S32_MAX) begin
			return 32'sh7fffffff;
		end else if (v < S32_MIN) begin
			return 32'sh80000000;
		end
		return v[WORD_W-1:0];
	endfunction

	// add a non-negative kernel value to a density sum, clamped at the top
	function automatic logic [CFG_W-1:0] dens_add(input logic [CFG_W-1:0] acc,
			input logic signed [WORD_W-1:0] k);
		logic [WORD_W-1:0] s;
		s = WORD_W'(acc) + WORD_W'(k[CFG_W-1:0]);
		return s[WORD_W-1] ? {CFG_W{1'b1}} : s[CFG_W-1:0];
	endfunction

	state_t state_q, state_d;

	// configuration
	logic [CFG_W-1:0] rad_q, dks_q, sks_q, vks_q, pg_q, vg_q;

	// centre particle and running sums
	logic signed [WORD_W-1:0] cpos_q [3];
	logic signed [WORD_W-1:0] cvel_q [3];
	logic [CFG_W-1:0]         cden_q;
	logic [CFG_W-1:0]         dacc_q;
	logic signed [WORD_W-1:0] pacc_q [3];
	logic signed [WORD_W-1:0] vacc_q [3];

	// current neighbour
	logic signed [WORD_W-1:0] pos_q [3];
	logic signed [WORD_W-1:0] vel_q [3];
	logic [CFG_W-1:0]         nden_q;
	logic                     last_q;

	// working registers
	logic signed [WORD_W:0]   off_q [3];
	logic [PROD_W-1:0]        sum_q;
	logic [WORD_W-1:0]        dist_q;
	logic signed [WORD_W-1:0] tmp_q, shared_q, slope_q, dir_q, w_q, infl_q;
	logic [1:0]               idx_q;
	logic [CFG_W-1:0]         fin_den_q;
	logic signed [WORD_W-1:0] fin_v_q [3];

	// result register
	logic                     res_valid_q;
	logic [CFG_W-1:0]         out_den_q;
	logic signed [WORD_W-1:0] out_p_q [3];
	logic signed [WORD_W-1:0] out_v_q [3];

	// shared units
	logic signed [WORD_W-1:0] mul_a, mul_b;
	logic signed [PROD_W-1:0] mul_prod;
	logic signed [WORD_W-1:0] mq;
	logic                     sqrt_start, sqrt_busy;
	logic [WORD_W-1:0]        sqrt_root;
	logic                     div_start, div_neg, div_busy;
	logic [MAG_W-1:0]         div_mag;
	logic [WORD_W-1:0]        div_den;
	logic signed [MAG_W:0]    div_quot;

	logic                     item_acc;
	logic                     res_free;
	logic signed [WORD_W:0]   off_w [3];
	logic                     oor_w;
	logic signed [WORD_W-1:0] rmd_w;
	logic signed [WORD_W:0]   psum_w;
	logic [PROD_W-1:0]        wdiff_w;
	logic [PROD_W-1:0]        wsh_w;
	logic signed [WORD_W-1:0] w_w;
	logic signed [WORD_W-1:0] dv_w;
	logic signed [WORD_W:0]   offabs_w;
	logic [WORD_W-1:0]        mqabs_w;

	sphpa_mul u_mul (
		.clk  (clk),
		.a    (mul_a),
		.b    (mul_b),
		.prod (mul_prod)
	);

	sphpa_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sqrt_start),
		.radicand (sum_q),
		.busy     (sqrt_busy),
		.root     (sqrt_root)
	);

	sphpa_div #(.MAG_W(MAG_W)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.neg      (div_neg),
		.dividend (div_mag),
		.divisor  (div_den),
		.busy     (div_busy),
		.quot     (div_quot)
	);

	assign item_stall = (state_q != ST_IDLE);
	assign item_acc   = item_valid && !item_stall;
	assign res_free   = !res_valid_q || !result_stall;

	// q-format product: floor shift then saturate
	assign mq = sat32(mul_prod >>> FRAC_BITS);

	// axis offsets and support check
	always_comb begin
		oor_w = 1'b0;
		for (int i = 0; i < 3; i++) begin
			off_w[i] = {cpos_q[i][WORD_W-1], cpos_q[i]} - {pos_q[i][WORD_W-1], pos_q[i]};
			if ($signed({off_w[i][WORD_W], off_w[i]}) >= $signed({2'b00, 1'b0, rad_q}) ||
			    -$signed({off_w[i][WORD_W], off_w[i]}) >= $signed({2'b00, 1'b0, rad_q})) begin
				oor_w = 1'b1;
			end
		end
	end

	assign rmd_w    = $signed({1'b0, rad_q}) - $signed(dist_q);
	assign psum_w   = {tmp_q[WORD_W-1], tmp_q} + {mq[WORD_W-1], mq};
	assign wdiff_w  = $unsigned(mul_prod) - sum_q;
	assign wsh_w    = wdiff_w >> FRAC_BITS;
	assign w_w      = (wsh_w > PROD_W'(32'h7fffffff)) ? 32'sh7fffffff : wsh_w[WORD_W-1:0];
	assign dv_w     = sat32(PROD_W'(vel_q[idx_q]) - PROD_W'(cvel_q[idx_q]));
	assign offabs_w = off_q[idx_q][WORD_W] ? -off_q[idx_q] : off_q[idx_q];
	assign mqabs_w  = mq[WORD_W-1] ? WORD_W'(-mq) : WORD_W'(mq);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// sequencer: next state and shared unit controls
	always_comb begin
		state_d    = state_q;
		mul_a      = '0;
		mul_b      = '0;
		sqrt_start = 1'b0;
		div_start  = 1'b0;
		div_neg    = 1'b0;
		div_mag    = '0;
		div_den    = dist_q;
		unique case (state_q)
			ST_IDLE: begin
				if (item_acc && opcode == OP_NEIGHBOUR) begin
					state_d = ST_OFF;
				end
			end
			ST_OFF:    state_d = oor_w ? ST_FIN : ST_SQ;
			ST_SQ: begin
				mul_a   = off_q[idx_q][WORD_W-1:0];
				mul_b   = off_q[idx_q][WORD_W-1:0];
				state_d = ST_SQ_ACC;
			end
			ST_SQ_ACC: state_d = (idx_q == 2'd2) ? ST_ROOT : ST_SQ;
			ST_ROOT: begin
				sqrt_start = 1'b1;
				state_d    = ST_ROOT_W;
			end
			ST_ROOT_W: begin
				if (!sqrt_busy) begin
					state_d = (sqrt_root >= {1'b0, rad_q}) ? ST_FIN : ST_DK1;
				end
			end
			ST_DK1: begin
				mul_a   = rmd_w;
				mul_b   = rmd_w;
				state_d = ST_DK2;
			end
			ST_DK2: begin
				mul_a   = mq;
				mul_b   = $signed({1'b0, dks_q});
				state_d = ST_DK3;
			end
			ST_DK3: state_d = (dist_q != '0 && cden_q != '0) ? ST_P1 : ST_W1;
			ST_P1: begin
				mul_a   = rmd_w;
				mul_b   = $signed({1'b0, sks_q});
				state_d = ST_P2;
			end
			ST_P2: begin
				mul_a   = $signed({1'b0, cden_q}) - ONE_Q;
				mul_b   = $signed({1'b0, pg_q});
				state_d = ST_P3;
			end
			ST_P3: begin
				mul_a   = $signed({1'b0, nden_q}) - ONE_Q;
				mul_b   = $signed({1'b0, pg_q});
				state_d = ST_P4;
			end
			ST_P4:     state_d = ST_PD;
			ST_PD: begin
				div_start = 1'b1;
				div_neg   = off_q[idx_q][WORD_W];
				div_mag   = MAG_W'(offabs_w[WORD_W-1:0]) << FRAC_BITS;
				div_den   = dist_q;
				state_d   = ST_PD_W;
			end
			ST_PD_W: begin
				if (!div_busy) begin
					state_d = ST_PM1;
				end
			end
			ST_PM1: begin
				mul_a   = shared_q;
				mul_b   = dir_q;
				state_d = ST_PM2;
			end
			ST_PM2: begin
				mul_a   = mq;
				mul_b   = slope_q;
				state_d = ST_PM3;
			end
			ST_PM3: begin
				div_start = 1'b1;
				div_neg   = mq[WORD_W-1];
				div_mag   = MAG_W'(mqabs_w) << FRAC_BITS;
				div_den   = WORD_W'(cden_q);
				state_d   = ST_PM_W;
			end
			ST_PM_W: begin
				if (!div_busy) begin
					state_d = (idx_q == 2'd2) ? ST_W1 : ST_PD;
				end
			end
			ST_W1: begin
				mul_a   = $signed({1'b0, rad_q});
				mul_b   = $signed({1'b0, rad_q});
				state_d = ST_W2;
			end
			ST_W2:     state_d = ST_W3;
			ST_W3: begin
				mul_a   = w_q;
				mul_b   = w_q;
				state_d = ST_W4;
			end
			ST_W4: begin
				mul_a   = mq;
				mul_b   = w_q;
				state_d = ST_W5;
			end
			ST_W5: begin
				mul_a   = mq;
				mul_b   = $signed({1'b0, vks_q});
				state_d = ST_W6;
			end
			ST_W6:     state_d = ST_V1;
			ST_V1: begin
				mul_a   = dv_w;
				mul_b   = infl_q;
				state_d = ST_V2;
			end
			ST_V2:     state_d = (idx_q == 2'd2) ? ST_FIN : ST_V1;
			ST_FIN:    state_d = last_q ? ST_FD1 : ST_IDLE;
			ST_FD1: begin
				mul_a   = $signed({1'b0, rad_q});
				mul_b   = $signed({1'b0, rad_q});
				state_d = ST_FD2;
			end
			ST_FD2: begin
				mul_a   = mq;
				mul_b   = $signed({1'b0, dks_q});
				state_d = ST_FD3;
			end
			ST_FD3:    state_d = ST_FV1;
			ST_FV1: begin
				mul_a   = vacc_q[idx_q];
				mul_b   = $signed({1'b0, vg_q});
				state_d = ST_FV2;
			end
			ST_FV2:    state_d = (idx_q == 2'd2) ? ST_EMIT : ST_FV1;
			ST_EMIT: begin
				if (res_free) begin
					state_d = ST_IDLE;
				end
			end
			default:   state_d = ST_IDLE;
		endcase
	end

	// configuration, centre state, sums and result handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rad_q       <= RADIUS_RST;
			dks_q       <= DENS_SCALE_RST;
			sks_q       <= SLOPE_SCALE_RST;
			vks_q       <= VISC_SCALE_RST;
			pg_q        <= PRESS_GAIN_RST;
			vg_q        <= VISC_GAIN_RST;
			cden_q      <= '0;
			dacc_q      <= '0;
			idx_q       <= '0;
			res_valid_q <= 1'b0;
			for (int i = 0; i < 3; i++) begin
				cpos_q[i] <= '0;
				cvel_q[i] <= '0;
				pacc_q[i] <= '0;
				vacc_q[i] <= '0;
			end
		end else begin
			if (cfg_write) begin
				unique case (cfg_reg_t'(cfg_index))
					REG_RADIUS:      rad_q <= cfg_data;
					REG_DENS_SCALE:  dks_q <= cfg_data;
					REG_SLOPE_SCALE: sks_q <= cfg_data;
					REG_VISC_SCALE:  vks_q <= cfg_data;
					REG_PRESS_GAIN:  pg_q  <= cfg_data;
					REG_VISC_GAIN:   vg_q  <= cfg_data;
					default: ;
				endcase
			end

			// the emit step refills the register itself when it leaves
			if (res_valid_q && !result_stall && state_q != ST_EMIT) begin
				res_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					idx_q <= '0;
					// load: take the centre particle and start fresh sums
					if (item_acc && opcode == OP_LOAD) begin
						cpos_q[0] <= pos_x;
						cpos_q[1] <= pos_y;
						cpos_q[2] <= pos_z;
						cvel_q[0] <= vel_x;
						cvel_q[1] <= vel_y;
						cvel_q[2] <= vel_z;
						cden_q    <= density;
						dacc_q    <= '0;
						for (int i = 0; i < 3; i++) begin
							pacc_q[i] <= '0;
							vacc_q[i] <= '0;
						end
					end
				end
				ST_SQ_ACC: idx_q <= (idx_q == 2'd2) ? 2'd0 : idx_q + 2'd1;
				ST_DK3:    dacc_q <= dens_add(dacc_q, mq);
				ST_P4:     idx_q <= '0;
				ST_PM_W: begin
					if (!div_busy) begin
						pacc_q[idx_q] <= sat32(PROD_W'(pacc_q[idx_q]) +
							PROD_W'(sat32(PROD_W'(div_quot))));
						idx_q <= (idx_q == 2'd2) ? 2'd0 : idx_q + 2'd1;
					end
				end
				ST_W6:     idx_q <= '0;
				ST_V2: begin
					vacc_q[idx_q] <= sat32(PROD_W'(vacc_q[idx_q]) + PROD_W'(mq));
					idx_q <= (idx_q == 2'd2) ? 2'd0 : idx_q + 2'd1;
				end
				ST_FD3:    idx_q <= '0;
				ST_FV2:    idx_q <= (idx_q == 2'd2) ? 2'd0 : idx_q + 2'd1;
				ST_EMIT: begin
					// result leaves, sums restart for the next run
					if (res_free) begin
						res_valid_q <= 1'b1;
						dacc_q      <= '0;
						for (int i = 0; i < 3; i++) begin
							pacc_q[i] <= '0;
							vacc_q[i] <= '0;
						end
					end
				end
				default: ;
			endcase
		end
	end

	// item capture, working values and result payload
	always_ff @(posedge clk) begin
		if (item_acc) begin
			pos_q[0] <= pos_x;
			pos_q[1] <= pos_y;
			pos_q[2] <= pos_z;
			vel_q[0] <= vel_x;
			vel_q[1] <= vel_y;
			vel_q[2] <= vel_z;
			nden_q   <= density;
			last_q   <= last;
		end
		case (state_q)
			ST_OFF: begin
				for (int i = 0; i < 3; i++) begin
					off_q[i] <= off_w[i];
				end
				sum_q <= '0;
			end
			ST_SQ_ACC: sum_q <= sum_q + $unsigned(mul_prod);
			ST_ROOT_W: dist_q <= sqrt_root;
			ST_P2:     slope_q <= -mq;
			ST_P3:     tmp_q <= mq;
			ST_P4:     shared_q <= psum_w[WORD_W:1];
			ST_PD_W:   dir_q <= div_quot[WORD_W-1:0];
			ST_W2:     w_q <= w_w;
			ST_W6:     infl_q <= mq;
			ST_FD3:    fin_den_q <= dens_add(dacc_q, mq);
			ST_FV2:    fin_v_q[idx_q] <= mq;
			ST_EMIT: begin
				if (res_free) begin
					out_den_q <= fin_den_q;
					for (int i = 0; i < 3; i++) begin
						out_p_q[i] <= pacc_q[i];
						out_v_q[i] <= fin_v_q[i];
					end
				end
			end
			default: ;
		endcase
	end

	assign result_valid = res_valid_q;
	assign density_sum  = out_den_q;
	assign pressure_x   = out_p_q[0];
	assign pressure_y   = out_p_q[1];
	assign pressure_z   = out_p_q[2];
	assign viscous_x    = out_v_q[0];
	assign viscous_y    = out_v_q[1];
	assign viscous_z    = out_v_q[2];

endmodule

/* src/sphpa_mul.sv */
// shared signed multiplier with registered product
module sphpa_mul import sphpa_pkg::*; (
	input  logic                     clk,
	input  logic signed [WORD_W-1:0] a,
	input  logic signed [WORD_W-1:0] b,
	output logic signed [PROD_W-1:0] prod
);

	logic signed [PROD_W-1:0] prod_q;

	always_ff @(posedge clk) begin
		prod_q <= a * b;
	end

	assign prod = prod_q;

endmodule

/* src/sphpa_sqrt.sv */
// iterative integer square root, two radicand bits per cycle
module sphpa_sqrt import sphpa_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [PROD_W-1:0] radicand,
	output logic              busy,
	output logic [WORD_W-1:0] root
);

	logic [PROD_W-1:0] rad_q;
	logic [WORD_W+1:0] rem_q;
	logic [WORD_W-1:0] root_q;
	logic [5:0]        cnt_q;
	logic              busy_q;

	logic [WORD_W+3:0] remx;
	logic [WORD_W+3:0] trial;
	logic [WORD_W+3:0] diff;
	logic              ge;

	assign remx  = {rem_q, rad_q[PROD_W-1 -: 2]};
	assign trial = (WORD_W+4)'({root_q, 2'b01});
	assign diff  = remx - trial;
	assign ge    = remx >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= 6'(WORD_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 6'd1;
			if (cnt_q == 6'd1) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= {rad_q[PROD_W-3:0], 2'b00};
			rem_q  <= ge ? diff[WORD_W+1:0] : remx[WORD_W+1:0];
			root_q <= {root_q[WORD_W-2:0], ge};
		end
	end

	assign busy = busy_q;
	assign root = root_q;

endmodule

/* src/sphpa_div.sv */
// iterative signed-magnitude divider, one quotient bit per cycle, truncating
module sphpa_div import sphpa_pkg::*; #(
	parameter int MAG_W = 48
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              neg,
	input  logic [MAG_W-1:0]  dividend,
	input  logic [WORD_W-1:0] divisor,
	output logic              busy,
	output logic signed [MAG_W:0] quot
);

	localparam int CNT_W = $clog2(MAG_W + 1);

	logic [MAG_W-1:0]  num_q;
	logic [WORD_W-1:0] rem_q;
	logic [WORD_W-1:0] den_q;
	logic              neg_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;

	logic [WORD_W:0] remx;
	logic [WORD_W:0] diff;
	logic            ge;

	assign remx = {rem_q, num_q[MAG_W-1]};
	assign diff = remx - {1'b0, den_q};
	assign ge   = remx >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(MAG_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			rem_q <= '0;
			den_q <= divisor;
			neg_q <= neg;
		end else if (busy_q) begin
			rem_q <= ge ? diff[WORD_W-1:0] : remx[WORD_W-1:0];
			num_q <= {num_q[MAG_W-2:0], ge};
		end
	end

	assign busy = busy_q;
	assign quot = neg_q ? -$signed({1'b0, num_q}) : $signed({1'b0, num_q});

endmodule
